FILE: sv/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg: shared constants of the linear probe hash table
// Default sizes, field widths, operation codes and result status codes.
// ---------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SIZE_DEF = 13;
   localparam int KEY_BITS_DEF   = 16;

   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int SLOT_INDEX_W = 4;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

FILE: sv/lpht_if.sv
// ---------------------------------------------------------------------------
// lpht request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface lpht_req_if #(
   parameter int KEY_BITS = lpht_pkg::KEY_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [lpht_pkg::MODE_W-1:0] mode;
   logic [KEY_BITS-1:0]         key;

   modport source (output valid, output mode, output key, input ready);
   modport sink   (input valid, input mode, input key, output ready);
endinterface

interface lpht_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lpht_pkg::STATUS_W-1:0]     status;
   logic [lpht_pkg::SLOT_INDEX_W-1:0] slot_index;

   modport source (output valid, output status, output slot_index, input ready);
   modport sink   (input valid, input status, input slot_index, output ready);
endinterface

FILE: sv/linear_probe_hash_table.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table: open addressing hash table with linear probing
// Insert, search and clear over TABLE_SIZE slots; home slot is key mod
// TABLE_SIZE and probing wraps from the last slot to slot 0.
//
//   channel    | dir | beat payload
//   req_chan   | in  | mode, key
//   rsp_chan   | out | status, slot_index
//
// Insert and search: accept, hash, probe (one slot memory read per cycle),
// then load the result. Clear: one slot per cycle, then load the result.
// A full insert and mode three go from accept straight to loading the result.
// Reset starts a clearing pass over all slots with req_chan not ready.
// The result register takes a new beat while the previous one is unread only
// after it drains; req_chan is ready whenever the sequencer is idle.
// ---------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   lpht_req_if.sink   req_chan,
   lpht_rsp_if.source rsp_chan
);

   localparam int IDX_BITS = $clog2(TABLE_SIZE);
   localparam int CNT_BITS = $clog2(TABLE_SIZE + 1);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(TABLE_SIZE - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(TABLE_SIZE);
   localparam logic [CNT_BITS-1:0] LAST_CNT  = CNT_BITS'(TABLE_SIZE - 1);

   logic [2:0]                      state_ff, state_in;
   logic [lpht_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [KEY_BITS-1:0]             key_ff, key_in;
   logic [CNT_BITS-1:0]             fill_ff, fill_in;
   logic [IDX_BITS-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [IDX_BITS-1:0]             cmp_ptr_ff, cmp_ptr_in;
   logic                            rd_live_ff, rd_live_in;
   logic [CNT_BITS-1:0]             iss_cnt_ff, iss_cnt_in;
   logic [CNT_BITS-1:0]             cmp_cnt_ff, cmp_cnt_in;
   logic [IDX_BITS-1:0]             clr_ptr_ff, clr_ptr_in;
   logic [lpht_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [IDX_BITS-1:0]             res_idx_ff, res_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::SLOT_INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic                            hash_start;
   logic                            hash_done;
   logic [IDX_BITS-1:0]             hash_home;
   logic                            wr_en;
   logic [IDX_BITS-1:0]             wr_addr;
   logic                            wr_used;
   logic                            rd_used;
   logic [KEY_BITS-1:0]             rd_key;
   logic                            req_beat;
   logic                            is_insert;
   logic                            hit;
   logic [IDX_BITS+lpht_pkg::SLOT_INDEX_W-1:0] idx_ext;

   lpht_hash #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_chan.key),
      .done  (hash_done),
      .home  (hash_home)
   );

   lpht_slot_store #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_used (wr_used),
      .wr_key  (key_ff),
      .rd_addr (rd_ptr_ff),
      .rd_used (rd_used),
      .rd_key  (rd_key)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_beat            = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_idx_ff;

   assign is_insert = (mode_ff == lpht_pkg::MODE_INSERT);
   assign hit       = is_insert ? !rd_used : (rd_used && (rd_key == key_ff));
   assign idx_ext   = {{lpht_pkg::SLOT_INDEX_W{1'b0}}, res_idx_ff};

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      fill_in       = fill_ff;
      rd_ptr_in     = rd_ptr_ff;
      cmp_ptr_in    = cmp_ptr_ff;
      rd_live_in    = 1'b0;
      iss_cnt_in    = iss_cnt_ff;
      cmp_cnt_in    = cmp_cnt_ff;
      clr_ptr_in    = clr_ptr_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      hash_start    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = clr_ptr_ff;
      wr_used       = 1'b0;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en      = 1'b1;
            fill_in    = '0;
            clr_ptr_in = (clr_ptr_ff == LAST_SLOT) ? '0 : clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == LAST_SLOT) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_FIN;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               mode_in       = req_chan.mode;
               key_in        = req_chan.key;
               res_status_in = lpht_pkg::STATUS_OK;
               res_idx_in    = '0;
               clr_ptr_in    = '0;
               case (req_chan.mode)
                  lpht_pkg::MODE_INSERT: begin
                     if (fill_ff == FULL_CNT) begin
                        res_status_in = lpht_pkg::STATUS_FULL;
                        state_in      = ST_FIN;
                     end else begin
                        hash_start = 1'b1;
                        state_in   = ST_HASH;
                     end
                  end
                  lpht_pkg::MODE_SEARCH: begin
                     hash_start = 1'b1;
                     state_in   = ST_HASH;
                  end
                  lpht_pkg::MODE_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               rd_ptr_in  = hash_home;
               iss_cnt_in = '0;
               cmp_cnt_in = '0;
               state_in   = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (iss_cnt_ff != FULL_CNT) begin
               rd_ptr_in  = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
               iss_cnt_in = iss_cnt_ff + 1'b1;
               rd_live_in = 1'b1;
               cmp_ptr_in = rd_ptr_ff;
            end
            if (rd_live_ff) begin
               cmp_cnt_in = cmp_cnt_ff + 1'b1;
               if (hit) begin
                  res_status_in = lpht_pkg::STATUS_OK;
                  res_idx_in    = cmp_ptr_ff;
                  state_in      = ST_FIN;
                  if (is_insert) begin
                     wr_en   = 1'b1;
                     wr_addr = cmp_ptr_ff;
                     wr_used = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (cmp_cnt_ff == LAST_CNT) begin
                  res_status_in = is_insert ? lpht_pkg::STATUS_FULL
                                            : lpht_pkg::STATUS_NOT_FOUND;
                  res_idx_in    = '0;
                  state_in      = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = idx_ext[lpht_pkg::SLOT_INDEX_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      rd_ptr_ff     <= rd_ptr_in;
      cmp_ptr_ff    <= cmp_ptr_in;
      iss_cnt_ff    <= iss_cnt_in;
      cmp_cnt_ff    <= cmp_cnt_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      if (reset) begin
         state_ff     <= ST_INIT;
         fill_ff      <= '0;
         rd_live_ff   <= 1'b0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_live_ff   <= rd_live_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/lpht_hash.sv
// ---------------------------------------------------------------------------
// lpht_hash: home slot unit
// Computes key mod TABLE_SIZE by reciprocal multiply, back multiply and one
// correcting subtract, over three registered steps.
// ---------------------------------------------------------------------------
module lpht_hash #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_BITS-1:0]           key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] home
);

   localparam int IDX_BITS = $clog2(TABLE_SIZE);
   localparam int SHIFT    = KEY_BITS + IDX_BITS;
   localparam int PROD_W   = 2 * KEY_BITS + 1;
   localparam int QT_W     = KEY_BITS + IDX_BITS + 1;
   localparam longint unsigned MULT_L = (64'd1 << SHIFT) / TABLE_SIZE;
   localparam logic [KEY_BITS:0] MULT = (KEY_BITS+1)'(MULT_L);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [KEY_BITS-1:0] qt_ff, qt_in;
   logic [2:0]          stage_ff, stage_in;
   logic [KEY_BITS-1:0] quot;
   logic [QT_W-1:0]     rem_raw;
   logic [QT_W-1:0]     rem_fix;

   always_comb begin
      key_in   = start ? key : key_ff;
      prod_in  = PROD_W'(key_ff) * PROD_W'(MULT);
      quot     = KEY_BITS'(prod_ff >> SHIFT);
      qt_in    = KEY_BITS'(QT_W'(quot) * QT_W'(TABLE_SIZE));
      stage_in = {stage_ff[1:0], start};
      rem_raw  = QT_W'(key_ff - qt_ff);
      rem_fix  = (rem_raw >= QT_W'(TABLE_SIZE)) ? rem_raw - QT_W'(TABLE_SIZE) : rem_raw;
   end

   assign done = stage_ff[2];
   assign home = IDX_BITS'(rem_fix);

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      prod_ff <= prod_in;
      qt_ff   <= qt_in;
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: sv/lpht_slot_store.sv
// ---------------------------------------------------------------------------
// lpht_slot_store: slot memory
// One entry per slot holding the used flag and the key; one write port and
// one registered read port.
// ---------------------------------------------------------------------------
module lpht_slot_store #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  logic                          wr_used,
   input  logic [KEY_BITS-1:0]           wr_key,
   input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output logic                          rd_used,
   output logic [KEY_BITS-1:0]           rd_key
);

   logic [KEY_BITS:0] mem [TABLE_SIZE];
   logic [KEY_BITS:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_used, wr_key};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_used = rd_data_ff[KEY_BITS];
   assign rd_key  = rd_data_ff[KEY_BITS-1:0];

endmodule

FILE: test/lpht_checker.sv
// ---------------------------------------------------------------------------
// lpht_checker: reply checker for the linear probe hash table
// Watches both channels and keeps a shadow copy of the slot keys, the valid
// bits and the fill count. Each request beat is applied to the shadow table
// to predict its reply. Each reply beat is compared with the oldest
// prediction. Reports the mismatch count and the number of replies due.
// ---------------------------------------------------------------------------
module lpht_checker #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   lpht_req_if  req_chan,
   lpht_rsp_if  rsp_chan,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [lpht_pkg::STATUS_W-1:0]     status;
      logic [lpht_pkg::SLOT_INDEX_W-1:0] slot_index;
   } table_reply_type;

   logic [KEY_BITS-1:0] shadow_key  [TABLE_SIZE];
   logic                shadow_used [TABLE_SIZE];
   int                  shadow_fill = 0;
   table_reply_type     replies_due [$];
   int                  mismatches  = 0;
   int                  n_due       = 0;

   assign fail_count = mismatches;
   assign pending    = n_due;

   function automatic int next_slot(input int s);
      return (s + 1 >= TABLE_SIZE) ? 0 : s + 1;
   endfunction

   function automatic table_reply_type apply_table_op(
      input logic [lpht_pkg::MODE_W-1:0] mode,
      input logic [KEY_BITS-1:0]         key
   );
      table_reply_type reply;
      int              s;
      bit              hit;
      reply.status     = lpht_pkg::STATUS_OK;
      reply.slot_index = '0;
      s   = int'(key) % TABLE_SIZE;
      hit = 1'b0;
      case (mode)
         lpht_pkg::MODE_INSERT: begin
            if (shadow_fill >= TABLE_SIZE) begin
               reply.status = lpht_pkg::STATUS_FULL;
            end else begin
               for (int n = 0; n < TABLE_SIZE && !hit; n++) begin
                  if (!shadow_used[s]) begin
                     shadow_used[s]   = 1'b1;
                     shadow_key[s]    = key;
                     shadow_fill++;
                     reply.slot_index = lpht_pkg::SLOT_INDEX_W'(s);
                     hit              = 1'b1;
                  end else begin
                     s = next_slot(s);
                  end
               end
            end
         end
         lpht_pkg::MODE_SEARCH: begin
            reply.status = lpht_pkg::STATUS_NOT_FOUND;
            for (int n = 0; n < TABLE_SIZE && !hit; n++) begin
               if (shadow_used[s] && shadow_key[s] == key) begin
                  reply.status     = lpht_pkg::STATUS_OK;
                  reply.slot_index = lpht_pkg::SLOT_INDEX_W'(s);
                  hit              = 1'b1;
               end else begin
                  s = next_slot(s);
               end
            end
         end
         lpht_pkg::MODE_CLEAR: begin
            foreach (shadow_used[i]) shadow_used[i] = 1'b0;
            shadow_fill = 0;
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      table_reply_type seen;
      table_reply_type due;
      if (reset) begin
         foreach (shadow_used[i]) shadow_used[i] = 1'b0;
         shadow_fill = 0;
         replies_due.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.status     = rsp_chan.status;
            seen.slot_index = rsp_chan.slot_index;
            if (replies_due.size() == 0) begin
               $display("%0t: reply beat with none expected, got status %0d slot %0d",
                        $time, seen.status, seen.slot_index);
               mismatches++;
            end else begin
               due = replies_due.pop_front();
               if (seen.status !== due.status || seen.slot_index !== due.slot_index) begin
                  $display("%0t: expected status %0d slot %0d, got status %0d slot %0d",
                           $time, due.status, due.slot_index,
                           seen.status, seen.slot_index);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            replies_due.push_back(apply_table_op(req_chan.mode, req_chan.key));
      end
      n_due = replies_due.size();
   end

endmodule

FILE: test/linear_probe_hash_table_test.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table_test: stimulus and verdict for the hash table
// Runs a directed pass over collisions, wrap-around, duplicates, a full
// table, absent keys, clear and the unused mode, then random traffic built
// from colliding key families, repeated keys and random keys, with random
// gaps on both channels, a long reply stall and a full drain.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_test;

   localparam int KEY_W        = lpht_pkg::KEY_BITS_DEF;
   localparam int TABLE_SIZE   = lpht_pkg::TABLE_SIZE_DEF;
   localparam logic [lpht_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
   localparam int RANDOM_ITEMS = 1280;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 40;

   logic             clock;
   logic             reset;
   int               fail_count;
   int               pending;
   bit               hold_rsp    = 1'b0;
   bit               steady      = 1'b0;
   int               idle_cycles = 0;
   logic [KEY_W-1:0] recent_keys [16];
   int               recent_cnt  = 0;
   int               family_home = 0;

   lpht_req_if #(.KEY_BITS(KEY_W)) req_chan ();
   lpht_rsp_if                     rsp_chan ();

   linear_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_W)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lpht_checker #(.TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_W)) table_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 3 && recent_cnt > 0)
         return recent_keys[$urandom_range(0, (recent_cnt < 16 ? recent_cnt : 16) - 1)];
      if (sel == 2) return KEY_W'($urandom);
      return KEY_W'(family_home + TABLE_SIZE * $urandom_range(0, 5040));
   endfunction

   task automatic offer(input logic [lpht_pkg::MODE_W-1:0] mode,
                        input logic [KEY_W-1:0] key);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.mode  <= mode;
      req_chan.key   <= key;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      gap = steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      logic [KEY_W-1:0]            fill_keys [8];
      logic [KEY_W-1:0]            k;
      logic [lpht_pkg::MODE_W-1:0] m;
      int                          r;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode  = lpht_pkg::MODE_INSERT;
      req_chan.key   = '0;
      fill_keys = '{16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                    16'h00FF, 16'hFF00, 16'd1, 16'd40};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer(lpht_pkg::MODE_CLEAR,  16'hFFFF);
      offer(lpht_pkg::MODE_SEARCH, 16'd0);
      offer(lpht_pkg::MODE_INSERT, 16'd0);
      offer(lpht_pkg::MODE_INSERT, 16'hFFFF);
      offer(lpht_pkg::MODE_INSERT, 16'd12);
      offer(lpht_pkg::MODE_INSERT, 16'd25);
      offer(lpht_pkg::MODE_INSERT, 16'd0);
      offer(lpht_pkg::MODE_SEARCH, 16'd0);
      offer(lpht_pkg::MODE_SEARCH, 16'd25);
      offer(lpht_pkg::MODE_SEARCH, 16'hFFFF);
      offer(lpht_pkg::MODE_SEARCH, 16'd100);
      offer(MODE_NOP,              16'hFFFF);
      foreach (fill_keys[i]) offer(lpht_pkg::MODE_INSERT, fill_keys[i]);
      offer(lpht_pkg::MODE_INSERT, 16'h1234);
      offer(lpht_pkg::MODE_SEARCH, 16'h0BAD);
      offer(lpht_pkg::MODE_CLEAR,  16'd0);
      offer(lpht_pkg::MODE_SEARCH, 16'd0);

      family_home = $urandom_range(0, TABLE_SIZE - 1);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 300 && i < 380) || (i >= 600 && i < 640);
         if (i == 600) hold_rsp = 1'b1;
         if (i == 1000) begin
            req_chan.valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            m           = lpht_pkg::MODE_CLEAR;
            k           = KEY_W'($urandom);
            recent_cnt  = 0;
            family_home = $urandom_range(0, TABLE_SIZE - 1);
         end else if (r < 6) begin
            m = MODE_NOP;
            k = KEY_W'($urandom);
         end else if (r < 50) begin
            m = lpht_pkg::MODE_INSERT;
            k = pick_key();
            recent_keys[recent_cnt % 16] = k;
            recent_cnt++;
         end else if (r < 85 && recent_cnt > 0) begin
            m = lpht_pkg::MODE_SEARCH;
            k = recent_keys[$urandom_range(0, (recent_cnt < 16 ? recent_cnt : 16) - 1)];
         end else begin
            m = lpht_pkg::MODE_SEARCH;
            k = pick_key();
         end
         offer(m, k);
      end

      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      int idle;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
         idle = gap_cycles();
         if (idle > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (idle) @(negedge clock);
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule
